FILE: rtl/hpc_pkg.sv
// Package: shared codes and constants for the half precision converter.
`timescale 1ns / 1ps
package hpc_pkg;
    typedef enum logic [1:0] {
        FUNC_TO_HALF   = 2'd0,
        FUNC_FROM_HALF = 2'd1,
        FUNC_CAP_HALF  = 2'd2,
        FUNC_UNUSED    = 2'd3
    } func_t;

    localparam logic [31:0] F32_INF_BITS   = 32'h7f80_0000;
    localparam logic [31:0] F16_INF_SCALED = 32'h0f80_0000;
    localparam logic [31:0] ROUND_ADD      = 32'h0000_1000;
    localparam logic [31:0] CAP_SIGNS      = 32'hC000_0000;
    localparam logic [31:0] CAP_KEEP       = 32'h07FF_E000;
    localparam logic [15:0] HALF_QNAN      = 16'h7e00;
    localparam logic [15:0] HALF_INF       = 16'h7c00;
    localparam logic [7:0]  SCALE_EXP      = 8'd112;

    // Control carried alongside the data through the pipeline.
    typedef struct packed {
        logic  valid;
        func_t func;
    } stage_ctl_t;
endpackage

FILE: rtl/half_precision_converter.sv
// Top level: three stage float32/float16 converter with valid/stall channels.
// A request is held in the stage 1 registers, then in stage 2, then in the stage 3
// output register, whose valid bit drives out_valid.
// Throughput: one request per cycle while the output is not stalled.
// Stall at a full output holds it and the run of full stages directly behind it;
// the input stall is asserted only when the first stage is full and cannot advance.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
module half_precision_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] value_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_bits
);
    // Stage 1: captured request.
    hpc_pkg::stage_ctl_t s1_reg;
    logic [31:0]         s1_val_reg;
    // Stage 2: scaled pattern plus the half to float result.
    hpc_pkg::stage_ctl_t s2_reg;
    logic [31:0]         s2_val_reg;
    logic [31:0]         s2_scaled_reg;
    logic [31:0]         s2_wide_reg;
    // Stage 3: output register.
    logic                s3_valid_reg;
    logic [31:0]         s3_res_reg;

    logic adv3, adv2, adv1;
    logic [31:0] scaled;
    logic [31:0] wide_next;
    logic [31:0] res_next;

    // Advance each stage when the stage ahead is empty or moving.
    assign adv3 = !s3_valid_reg || !out_stall;
    assign adv2 = !s2_reg.valid || adv3;
    assign adv1 = !s1_reg.valid || adv2;
    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg.valid <= 1'b0;
            s1_reg.func  <= hpc_pkg::FUNC_TO_HALF;
            s2_reg.valid <= 1'b0;
            s2_reg.func  <= hpc_pkg::FUNC_TO_HALF;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_reg.valid <= in_valid;
                s1_reg.func  <= hpc_pkg::func_t'(func);
            end
            if (adv2)
            begin
                s2_reg <= s1_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_reg.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_val_reg <= value_bits;
        end
        if (adv2)
        begin
            s2_val_reg    <= s1_val_reg;
            s2_scaled_reg <= scaled;
            s2_wide_reg   <= wide_next;
        end
        if (adv3)
        begin
            s3_res_reg <= res_next;
        end
    end

    // Clear the low 12 bits before scaling, as the rounding recipe requires.
    hpc_scale u_scale
    (
        .mag    ({s1_val_reg[30:12], 12'd0}),
        .scaled (scaled)
    );

    // Half to float: renormalize denormals with a leading one search.
    always_comb
    begin
        logic [4:0]  he;
        logic [9:0]  hm;
        logic [3:0]  p;
        logic [22:0] nm;
        he = s1_val_reg[14:10];
        hm = s1_val_reg[9:0];
        p  = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (hm[i])
            begin
                p = 4'(i);
            end
        end
        nm = 23'({hm, 13'd0} << (4'd10 - p));
        if (he == 5'd31)
        begin
            wide_next = {1'b0, 8'hff, hm, 13'd0};
        end
        else if (he != 5'd0)
        begin
            wide_next = {1'b0, 8'({3'd0, he} + 8'd112), hm, 13'd0};
        end
        else if (hm == 10'd0)
        begin
            wide_next = 32'd0;
        end
        else
        begin
            wide_next = {1'b0, 8'({4'd0, p} + 8'd103), nm};
        end
        wide_next[31] = s1_val_reg[15];
    end

    // Final stage: round bias, clamp and format select.
    always_comb
    begin
        logic [31:0] r;
        logic [31:0] rc;
        logic [30:0] mag;
        logic [15:0] o;
        r   = s2_scaled_reg + hpc_pkg::ROUND_ADD;
        rc  = (r > hpc_pkg::F16_INF_SCALED) ? hpc_pkg::F16_INF_SCALED : r;
        mag = s2_val_reg[30:0];
        if ({1'b0, mag} > hpc_pkg::F32_INF_BITS)
        begin
            o = hpc_pkg::HALF_QNAN;
        end
        else if ({1'b0, mag} == hpc_pkg::F32_INF_BITS)
        begin
            o = hpc_pkg::HALF_INF;
        end
        else
        begin
            o = rc[28:13];
        end
        o[15] = s2_val_reg[31];
        unique case (s2_reg.func)
            hpc_pkg::FUNC_TO_HALF:   res_next = {16'd0, o};
            hpc_pkg::FUNC_FROM_HALF: res_next = s2_wide_reg;
            hpc_pkg::FUNC_CAP_HALF:
                res_next = (s2_val_reg & hpc_pkg::CAP_SIGNS) | (r & hpc_pkg::CAP_KEEP);
            default:                 res_next = 32'd0;
        endcase
    end

    assign out_valid   = s3_valid_reg;
    assign result_bits = s3_res_reg;

    // A stalled result must hold until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_bits))
        else $error("result changed under stall");
    // A full stage two waiting on a stalled output keeps the input stalled
    // once stage one is also full.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid && s2_reg.valid && s3_valid_reg && out_stall |-> in_stall)
        else $error("input not stalled with full pipeline");
    // Stage two keeps its item while stage three cannot take it.
    a_adv: assert property (@(posedge clk) disable iff (!rst_n)
        s2_reg.valid && !adv3 |=> s2_reg.valid)
        else $error("stage two dropped an item");
endmodule

FILE: rtl/hpc_scale.sv
// Scale stage: float32 magnitude times 2^-112 with round to nearest even; Inf and NaN pass through, NaN made quiet.
`timescale 1ns / 1ps
module hpc_scale
(
    input  logic [30:0] mag,
    output logic [31:0] scaled
);
    logic [7:0]  e;
    logic [22:0] m;
    logic [23:0] sig;
    logic [7:0]  s;
    logic [4:0]  sh;
    logic [23:0] q;
    logic [23:0] rem_mask;
    logic [23:0] rem;
    logic [23:0] half;
    logic [23:0] q_rnd;

    assign e   = mag[30:23];
    assign m   = mag[22:0];
    assign sig = (e != 8'd0) ? {1'b1, m} : {1'b0, m};
    assign s   = (hpc_pkg::SCALE_EXP + 8'd1) - ((e != 8'd0) ? e : 8'd1);
    assign sh  = s[4:0];
    assign q        = sig >> sh;
    assign rem_mask = (24'd1 << sh) - 24'd1;
    assign rem      = sig & rem_mask;
    assign half     = 24'd1 << (sh - 5'd1);
    assign q_rnd    = ((rem > half) || ((rem == half) && q[0])) ? q + 24'd1 : q;

    always_comb
    begin
        if (e == 8'hff)
        begin
            scaled = (m != 23'd0) ? {1'b0, mag | 31'h0040_0000} : {1'b0, mag};
        end
        else if (e >= hpc_pkg::SCALE_EXP + 8'd1)
        begin
            scaled = {1'b0, mag} - {1'b0, hpc_pkg::SCALE_EXP, 23'd0};
        end
        else if (s > 8'd24)
        begin
            // Shift beyond the significand: at most a rounding of zero remains.
            scaled = 32'd0;
        end
        else
        begin
            scaled = {8'd0, q_rnd};
        end
    end
endmodule
